// ----- rtl/pjm_pkg.sv -----
// shared types and constants for the period jitter monitor
`timescale 1ns / 1ps

package pjm_pkg;

    localparam int TIME_WIDTH   = 64;
    localparam int PERIOD_WIDTH = 62;
    localparam int STAT_WIDTH   = 64;
    localparam int OUT_FIELDS   = 6;
    localparam int OUT_WIDTH    = OUT_FIELDS * STAT_WIDTH;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(200000);
    localparam logic [STAT_WIDTH-1:0]   NO_INTERVAL  = '1;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] start_time;
        logic [STAT_WIDTH-1:0] count;
        logic [STAT_WIDTH-1:0] recent;
        logic [STAT_WIDTH-1:0] largest;
        logic [STAT_WIDTH-1:0] smallest;
        logic [STAT_WIDTH-1:0] jitter;
        logic [STAT_WIDTH-1:0] overrun;
    } t_stats;

    localparam t_stats STATS_RESET = '{
        start_time: '0,
        count:      '0,
        recent:     '0,
        largest:    '0,
        smallest:   NO_INTERVAL,
        jitter:     '0,
        overrun:    '0
    };

endpackage

// ----- rtl/pjm_stats_calc.sv -----
// next-state logic for the interval statistics of one transfer
`timescale 1ns / 1ps

module pjm_stats_calc (
    input  pjm_pkg::t_stats                     i_cur,
    input  pjm_pkg::t_kind                      i_kind,
    input  logic [pjm_pkg::TIME_WIDTH-1:0]      i_now,
    input  logic [pjm_pkg::PERIOD_WIDTH-1:0]    i_period,
    output pjm_pkg::t_stats                     o_nxt
);
    import pjm_pkg::*;

    logic [TIME_WIDTH-1:0]   interval_t;
    logic [STAT_WIDTH-1:0]   interval;
    logic [STAT_WIDTH-1:0]   period;
    logic [STAT_WIDTH-1:0]   period_x2;
    logic [STAT_WIDTH-1:0]   jit_above;
    logic [STAT_WIDTH-1:0]   jit_below;
    logic [STAT_WIDTH-1:0]   jitter;
    logic                    valid_interval;

    assign interval_t     = i_now - i_cur.start_time;
    assign interval       = STAT_WIDTH'(interval_t);
    assign period         = STAT_WIDTH'(i_period);
    assign period_x2      = STAT_WIDTH'({i_period, 1'b0});
    assign jit_above      = interval - period;
    assign jit_below      = period - interval;
    assign jitter         = (interval >= period) ? jit_above : jit_below;
    // first sample after reset or clear, or time went backwards
    assign valid_interval = (i_cur.start_time != '0) && (i_now >= i_cur.start_time);

    always_comb begin
        o_nxt = i_cur;
        if (i_kind == KIND_CLEAR) begin
            o_nxt = STATS_RESET;
        end else begin
            o_nxt.start_time = i_now;
            if (valid_interval) begin
                o_nxt.recent = interval;
                o_nxt.count  = i_cur.count + STAT_WIDTH'(1);
                if (interval > i_cur.largest) begin
                    o_nxt.largest = interval;
                end
                if (interval < i_cur.smallest) begin
                    o_nxt.smallest = interval;
                end
                if (jitter > i_cur.jitter) begin
                    o_nxt.jitter = jitter;
                end
                if (interval >= period_x2) begin
                    o_nxt.overrun = i_cur.overrun + STAT_WIDTH'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/period_jitter_monitor.sv -----
// period jitter monitor top level: input stage, statistics registers, output register
`timescale 1ns / 1ps
// an input transfer is held in the input stage, then its result in the output register on the master side
// throughput: one transfer per cycle while the master side accepts, with a combinational statistics update
// the output register decouples the sides, so one more input is taken while a result waits
// reset (synchronous, active low): statistics cleared, minimum tracker all ones,
// period back to 200000 ns, both pipeline stages empty

module period_jitter_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel: period_ns
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pjm_pkg::PERIOD_WIDTH-1:0]    i_cfg_data,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [63:0]                         i_s_axis_tdata,   // now_ns
    input  logic                                i_s_axis_tuser,   // kind
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // sample_count, last_interval, interval_min, interval_max, max_jitter, overrun_count
    output logic [pjm_pkg::OUT_WIDTH-1:0]       o_m_axis_tdata
);
    import pjm_pkg::*;

    logic                    r_in_valid;
    t_kind                   r_in_kind;
    logic [TIME_WIDTH-1:0]   r_in_now;
    logic [PERIOD_WIDTH-1:0] r_period;
    t_stats                  r_stats;
    t_stats                  n_stats;
    logic                    r_out_valid;
    logic [OUT_WIDTH-1:0]    r_out_data;
    logic [STAT_WIDTH-1:0]   min_shown;

    logic                    advance;
    logic                    s_ready;
    logic                    s_fire;
    logic                    work_fire;

    // result stage moves when empty or being drained
    assign advance   = !r_out_valid || i_m_axis_tready;
    assign s_ready   = !r_in_valid || advance;
    assign s_fire    = i_s_axis_tvalid && s_ready;
    assign work_fire = r_in_valid && advance;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    pjm_stats_calc u_calc (
        .i_cur    (r_stats),
        .i_kind   (r_in_kind),
        .i_now    (r_in_now),
        .i_period (r_period),
        .o_nxt    (n_stats)
    );

    // minimum reads as zero until a first interval lands
    assign min_shown = (n_stats.smallest == NO_INTERVAL) ? '0 : n_stats.smallest;

    // control and statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RESET;
            r_stats     <= STATS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (s_ready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (work_fire) begin
                r_stats <= n_stats;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_kind <= t_kind'(i_s_axis_tuser);
            r_in_now  <= i_s_axis_tdata[TIME_WIDTH-1:0];
        end
        if (work_fire) begin
            r_out_data <= {n_stats.overrun, n_stats.jitter, n_stats.largest,
                           min_shown, n_stats.recent, n_stats.count};
        end
    end

endmodule

// ----- dv/period_jitter_monitor_test.sv -----
// self-checking testbench for the period jitter monitor: directed and random timestamp streams
`timescale 1ns / 1ps

module period_jitter_monitor_test;

    import pjm_pkg::*;

    localparam int IDLE_LIMIT   = 2000;   // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES = 4;      // covers the input and output stages with margin
    localparam int RANDOM_ITEMS = 200;    // per random stream test
    localparam int DRAIN_EVERY  = 64;

    localparam logic [PERIOD_WIDTH-1:0] EDGE_PERIODS [4] = '{
        '0, PERIOD_WIDTH'(1), '1, PERIOD_RESET
    };

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [PERIOD_WIDTH-1:0] i_cfg_data      = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [63:0]             i_s_axis_tdata  = '0;   // now_ns
    logic                    i_s_axis_tuser  = 1'b0; // kind
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // sample_count, last_interval, interval_min, interval_max, max_jitter, overrun_count
    logic [OUT_WIDTH-1:0]    o_m_axis_tdata;

    period_jitter_monitor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the monitor
    logic [PERIOD_WIDTH-1:0] period_setting = PERIOD_RESET;
    logic [63:0] last_start;
    logic [63:0] interval_total;
    logic [63:0] newest_interval;
    logic [63:0] longest_interval;
    logic [63:0] shortest_interval;
    logic [63:0] worst_jitter;
    logic [63:0] overrun_total;

    logic [OUT_WIDTH-1:0] expected_stats [$];
    int   error_count   = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic [63:0] stream_time;

    const string FIELD_NAMES [OUT_FIELDS] = '{
        "sample_count", "last_interval", "interval_min",
        "interval_max", "max_jitter", "overrun_count"
    };

    function automatic void clear_monitor();
        last_start        = '0;
        interval_total    = '0;
        newest_interval   = '0;
        longest_interval  = '0;
        shortest_interval = NO_INTERVAL;
        worst_jitter      = '0;
        overrun_total     = '0;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] predict_stats(input t_kind kind,
                                                           input logic [63:0] now_ns);
        logic [63:0] prev;
        logic [63:0] span;
        logic [63:0] period64;
        logic [63:0] deviation;
        prev     = last_start;
        period64 = 64'(period_setting);
        if (kind == KIND_CLEAR) begin
            clear_monitor();
        end else begin
            last_start = now_ns;
            // a zero start means first sample; going backwards only moves the start
            if (prev != 0 && now_ns >= prev) begin
                span            = now_ns - prev;
                newest_interval = span;
                interval_total  = interval_total + 1;
                if (span > longest_interval) longest_interval = span;
                if (span < shortest_interval) shortest_interval = span;
                deviation = (span >= period64) ? span - period64 : period64 - span;
                if (deviation > worst_jitter) worst_jitter = deviation;
                if (span >= {1'b0, period_setting, 1'b0}) overrun_total = overrun_total + 1;
            end
        end
        return {overrun_total, worst_jitter, longest_interval,
                (shortest_interval == NO_INTERVAL) ? 64'd0 : shortest_interval,
                newest_interval, interval_total};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one transfer on the slave side, with random idle cycles ahead of it
    task automatic send_item(input t_kind kind, input logic [63:0] now_ns);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= now_ns;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            if (taken) expected_stats.push_back(predict_stats(kind, now_ns));
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_WIDTH-1:0] value);
        bit taken;
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            if (taken) period_setting = value;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // first samples, exact period, short and long intervals, zero interval,
    // time going backwards, huge interval and a clear
    task automatic test_sample_sequence();
        send_item(KIND_SAMPLE, 64'd0);
        send_item(KIND_SAMPLE, 64'd1000);
        send_item(KIND_SAMPLE, 64'd201000);
        send_item(KIND_SAMPLE, 64'd351000);
        send_item(KIND_SAMPLE, 64'd751000);
        send_item(KIND_SAMPLE, 64'd751000);
        send_item(KIND_SAMPLE, 64'd500);
        send_item(KIND_SAMPLE, '1);
        send_item(KIND_CLEAR, '1);
    endtask

    // zero, smallest, largest and reset period, each with an exact overrun
    task automatic test_period_extremes();
        logic [63:0] p;
        foreach (EDGE_PERIODS[i]) begin
            write_period(EDGE_PERIODS[i]);
            p = 64'(EDGE_PERIODS[i]);
            send_item(KIND_CLEAR, 64'd0);
            send_item(KIND_SAMPLE, 64'd10);
            send_item(KIND_SAMPLE, 64'd10 + p);
            send_item(KIND_SAMPLE, 64'd10 + 3 * p);
        end
    endtask

    task automatic pick_next_item(output t_kind kind, output logic [63:0] now_ns);
        int          choice;
        logic [63:0] p;
        logic [63:0] span;
        choice = $urandom_range(99);
        p      = 64'(period_setting);
        kind   = KIND_SAMPLE;
        if (choice < 70) begin
            // regular tick with jitter around the period
            span        = p >> $urandom_range(1, 6);
            stream_time = stream_time + p - span + rand64() % (2 * span + 1);
        end else if (choice < 80) begin
            // at, just under or beyond twice the period
            case ($urandom_range(2))
                0: stream_time = stream_time + 2 * p;
                1: stream_time = stream_time + 2 * p - 1;
                default: stream_time = stream_time + 2 * p + $urandom_range(1, 1000);
            endcase
        end else if (choice < 85) begin
            stream_time = stream_time - $urandom_range(1, 1000);
        end else if (choice < 89) begin
            kind = KIND_CLEAR;
        end else if (choice < 92) begin
            stream_time = '0;
        end else if (choice < 96) begin
            stream_time = rand64();
        end else begin
            stream_time = stream_time + $urandom_range(1);
        end
        now_ns = (kind == KIND_CLEAR) ? rand64() : stream_time;
    endtask

    task automatic test_random_stream(input int idle_pct, input int stall,
                                      input logic [PERIOD_WIDTH-1:0] period);
        t_kind       kind;
        logic [63:0] now_ns;
        write_period(period);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        stream_time   = rand64() >> $urandom_range(1, 8);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // sender holds off until the pipeline is empty now and then
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_for_results();
            pick_next_item(kind, now_ns);
            send_item(kind, now_ns);
        end
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result check: sample the handshake mid-cycle, compare at the edge
    initial begin
        logic                 fired;
        logic [OUT_WIDTH-1:0] seen;
        logic [OUT_WIDTH-1:0] want;
        forever begin
            @(negedge i_clk);
            fired = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
            seen  = o_m_axis_tdata;
            @(posedge i_clk);
            if (fired) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, seen);
                    error_count++;
                end else begin
                    want = expected_stats.pop_front();
                    for (int f = 0; f < OUT_FIELDS; f++) begin
                        if (seen[f*STAT_WIDTH +: STAT_WIDTH] !== want[f*STAT_WIDTH +: STAT_WIDTH]) begin
                            $display("%0t: %s expected %h actual %h", $time, FIELD_NAMES[f],
                                     want[f*STAT_WIDTH +: STAT_WIDTH],
                                     seen[f*STAT_WIDTH +: STAT_WIDTH]);
                            error_count++;
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        clear_monitor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_sequence();
        test_period_extremes();
        test_random_stream(0, 0, PERIOD_RESET);
        test_random_stream(47, 0, PERIOD_WIDTH'($urandom_range(1, 5000)));
        test_random_stream(0, 47, PERIOD_WIDTH'(rand64()));
        test_random_stream(18, 18, PERIOD_WIDTH'(1));

        wait_for_results();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
